[rtl/slps_pkg.sv]
// ----------------------------------------------------------------------------
// slps_pkg
// Types and constants shared by the serial link poll supervisor files.
// ----------------------------------------------------------------------------
`default_nettype none

package slps_pkg;

    localparam int RX_COUNT_W  = 8;
    localparam int CHECK_W     = 3;
    localparam int LIMIT_W     = 16;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Input opcodes
    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_IDLE_LINE = 1'b1;

    // Command kinds as held for an outstanding command
    localparam logic KIND_SYNC   = 1'b0;
    localparam logic KIND_ACTION = 1'b1;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_BUSY_LIMIT    = 2'd0;
    localparam logic [1:0] REG_SETTLE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_SYNC_INTERVAL = 2'd2;
    localparam logic [1:0] REG_SYNC_ENABLE   = 2'd3;

    localparam logic [LIMIT_W-1:0] BUSY_LIMIT_RST    = 16'd100;
    localparam logic [LIMIT_W-1:0] SETTLE_LIMIT_RST  = 16'd10;
    localparam logic [LIMIT_W-1:0] SYNC_INTERVAL_RST = 16'd100;
    localparam logic               SYNC_ENABLE_RST   = 1'b1;

    typedef enum logic [1:0] {
        SEND_NONE   = 2'd0,
        SEND_SYNC   = 2'd1,
        SEND_ACTION = 2'd2
    } send_cmd_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] busy_limit;
        logic [LIMIT_W-1:0] settle_limit;
        logic [LIMIT_W-1:0] sync_interval;
        logic               sync_enable;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/slps_ifs.sv]
// ----------------------------------------------------------------------------
// slps channel interfaces
// Request (tick / idle-line event) and response beat channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface slps_req_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [slps_pkg::RX_COUNT_W-1:0]     rx_count;
    logic                                action_pending;
    logic [slps_pkg::CHECK_W-1:0]        reply_check;

    modport source (
        output valid, opcode, rx_count, action_pending, reply_check,
        input  ready
    );
    modport sink (
        input  valid, opcode, rx_count, action_pending, reply_check,
        output ready
    );
endinterface

interface slps_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                reply_done;
    logic                                reply_kind;
    logic                                reply_timed_out;
    logic [slps_pkg::CHECK_W-1:0]        reply_code;
    logic [1:0]                          send_cmd;
    logic                                link_connected;
    logic                                link_is_busy;

    modport source (
        output valid, reply_done, reply_kind, reply_timed_out, reply_code,
               send_cmd, link_connected, link_is_busy,
        input  ready
    );
    modport sink (
        input  valid, reply_done, reply_kind, reply_timed_out, reply_code,
               send_cmd, link_connected, link_is_busy,
        output ready
    );
endinterface

`default_nettype wire

[rtl/serial_link_poll_supervisor.sv]
// ----------------------------------------------------------------------------
// serial_link_poll_supervisor
// Supervises one command/response serial link: reply timeout, reply
// resolution, connection settling and sync/action command issue.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | beat payload
//  req     | in  | valid/ready   | opcode, rx_count, action_pending, reply_check
//  rsp     | out | valid/ready   | reply_done/kind/timed_out/code, send_cmd,
//          |     |               | link_connected, link_is_busy
//  apb     | in  | psel/penable  | 4 config registers at 4*i, pready tied high
//
// One beat per cycle sustained while rsp.ready stays high; a result passes the
// input register, then the result register (state update between). req.ready
// drops only when both the input and result registers are full and rsp.ready is
// low. Reset clears link state but sets reply_lost; loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_link_poll_supervisor #(
    parameter int RX_BUFFER_BYTES = 128,
    parameter int COUNTER_BITS    = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    slps_req_if.sink                                 req,
    slps_rsp_if.source                               rsp,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [slps_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [slps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [slps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    localparam int CB = COUNTER_BITS;
    localparam int CW = (COUNTER_BITS > slps_pkg::LIMIT_W) ? COUNTER_BITS
                                                            : slps_pkg::LIMIT_W;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
    localparam logic [slps_pkg::RX_COUNT_W-1:0] RX_MAX =
        slps_pkg::RX_COUNT_W'(RX_BUFFER_BYTES);

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    slps_pkg::cfg_t cfg;

    slps_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    logic                               s1_valid_reg;
    logic                               s1_opcode_reg;
    logic [slps_pkg::RX_COUNT_W-1:0]    s1_rx_count_reg;
    logic                               s1_action_reg;
    logic [slps_pkg::CHECK_W-1:0]       s1_check_reg;

    // Result register
    logic                               o_valid_reg;
    logic                               o_done_reg;
    logic                               o_kind_reg;
    logic                               o_tmo_reg;
    logic [slps_pkg::CHECK_W-1:0]       o_code_reg;
    slps_pkg::send_cmd_t                o_send_reg;
    logic                               o_conn_reg;
    logic                               o_busy_reg;

    // Link state
    logic                               waiting_reply_reg,   waiting_reply_next;
    logic [CB-1:0]                      busy_ticks_reg,      busy_ticks_next;
    logic [CB-1:0]                      sync_wait_reg,       sync_wait_next;
    logic                               connected_reg,       connected_next;
    logic                               conn_before_reg,     conn_before_next;
    logic                               outstanding_reg,     outstanding_next;
    logic                               reply_lost_reg,      reply_lost_next;
    logic                               out_kind_reg,        out_kind_next;
    logic                               settle_needed_reg,   settle_needed_next;
    logic [CB-1:0]                      settle_ticks_reg,    settle_ticks_next;
    logic [slps_pkg::RX_COUNT_W-1:0]    rx_bytes_reg,        rx_bytes_next;
    logic [slps_pkg::RX_COUNT_W-1:0]    rx_before_reg,       rx_before_next;

    // Result of the item in the input register
    logic                               r_done;
    logic                               r_kind;
    logic                               r_tmo;
    logic [slps_pkg::CHECK_W-1:0]       r_code;
    slps_pkg::send_cmd_t                r_send;

    logic                               out_load;
    logic                               s1_adv;
    logic                               req_take;

    logic [CB-1:0]                      bt_inc;
    logic [CB-1:0]                      st_inc;
    logic                               settle_now;
    logic                               may_send;
    logic                               sync_due;
    logic [CW-1:0]                      interval_w;
    logic [CB-1:0]                      interval_sat;

    assign out_load  = !o_valid_reg || rsp.ready;
    assign s1_adv    = s1_valid_reg && out_load;
    assign req.ready = !s1_valid_reg || out_load;
    assign req_take  = req.valid && req.ready;

    assign bt_inc     = sat_inc(busy_ticks_reg);
    assign st_inc     = sat_inc(settle_ticks_reg);
    assign interval_w = CW'(cfg.sync_interval);
    assign sync_due   = CW'(sync_wait_reg) >= interval_w;
    assign interval_sat = (interval_w > CW'(CNT_MAX)) ? CNT_MAX : CB'(interval_w);

    always_comb
    begin
        waiting_reply_next = waiting_reply_reg;
        busy_ticks_next    = busy_ticks_reg;
        sync_wait_next     = sync_wait_reg;
        connected_next     = connected_reg;
        conn_before_next   = conn_before_reg;
        outstanding_next   = outstanding_reg;
        reply_lost_next    = reply_lost_reg;
        out_kind_next      = out_kind_reg;
        settle_needed_next = settle_needed_reg;
        settle_ticks_next  = settle_ticks_reg;
        rx_bytes_next      = rx_bytes_reg;
        rx_before_next     = rx_before_reg;
        r_done     = 1'b0;
        r_kind     = slps_pkg::KIND_SYNC;
        r_tmo      = 1'b0;
        r_code     = '0;
        r_send     = slps_pkg::SEND_NONE;
        settle_now = 1'b0;
        may_send   = 1'b0;

        if (s1_opcode_reg == slps_pkg::OP_IDLE_LINE)
        begin
            rx_bytes_next = (s1_rx_count_reg > RX_MAX) ? RX_MAX : s1_rx_count_reg;
            if (s1_rx_count_reg != '0)
            begin
                waiting_reply_next = 1'b0;
            end
        end
        else if (waiting_reply_reg)
        begin
            busy_ticks_next = bt_inc;
            if (CW'(bt_inc) > CW'(cfg.busy_limit))
            begin
                reply_lost_next    = 1'b1;
                waiting_reply_next = 1'b0;
            end
        end
        else
        begin
            // Resolve the outstanding command first
            if (outstanding_reg)
            begin
                r_done           = 1'b1;
                r_kind           = out_kind_reg;
                r_tmo            = reply_lost_reg;
                r_code           = reply_lost_reg ? '0 : s1_check_reg;
                reply_lost_next  = 1'b0;
                outstanding_next = 1'b0;
                connected_next   = !reply_lost_reg;
            end

            // Hold off sending until rx count is stable after a fresh connect
            settle_now       = settle_needed_reg || (!conn_before_reg && connected_next);
            conn_before_next = connected_next;
            if (!settle_now)
            begin
                may_send = 1'b1;
            end
            else
            begin
                settle_needed_next = 1'b1;
                rx_before_next     = rx_bytes_reg;
                if (rx_before_reg == rx_bytes_reg)
                begin
                    settle_ticks_next = st_inc;
                    if (CW'(st_inc) >= CW'(cfg.settle_limit))
                    begin
                        settle_ticks_next  = '0;
                        settle_needed_next = 1'b0;
                        may_send           = 1'b1;
                    end
                end
                else
                begin
                    settle_ticks_next = '0;
                end
            end

            if (may_send)
            begin
                if (connected_next && s1_action_reg)
                begin
                    sync_wait_next     = interval_sat;
                    busy_ticks_next    = '0;
                    waiting_reply_next = 1'b1;
                    outstanding_next   = 1'b1;
                    out_kind_next      = slps_pkg::KIND_ACTION;
                    r_send             = slps_pkg::SEND_ACTION;
                end
                else if (!connected_next || cfg.sync_enable)
                begin
                    if (sync_due)
                    begin
                        sync_wait_next     = '0;
                        busy_ticks_next    = '0;
                        waiting_reply_next = 1'b1;
                        outstanding_next   = 1'b1;
                        out_kind_next      = slps_pkg::KIND_SYNC;
                        r_send             = slps_pkg::SEND_SYNC;
                    end
                    else
                    begin
                        sync_wait_next = sat_inc(sync_wait_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            o_valid_reg       <= 1'b0;
            waiting_reply_reg <= 1'b0;
            busy_ticks_reg    <= '0;
            sync_wait_reg     <= '0;
            connected_reg     <= 1'b0;
            conn_before_reg   <= 1'b0;
            outstanding_reg   <= 1'b0;
            reply_lost_reg    <= 1'b1;
            out_kind_reg      <= slps_pkg::KIND_SYNC;
            settle_needed_reg <= 1'b0;
            settle_ticks_reg  <= '0;
            rx_bytes_reg      <= '0;
            rx_before_reg     <= '0;
        end
        else
        begin
            if (req_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                o_valid_reg <= s1_valid_reg;
            end

            if (s1_adv)
            begin
                waiting_reply_reg <= waiting_reply_next;
                busy_ticks_reg    <= busy_ticks_next;
                sync_wait_reg     <= sync_wait_next;
                connected_reg     <= connected_next;
                conn_before_reg   <= conn_before_next;
                outstanding_reg   <= outstanding_next;
                reply_lost_reg    <= reply_lost_next;
                out_kind_reg      <= out_kind_next;
                settle_needed_reg <= settle_needed_next;
                settle_ticks_reg  <= settle_ticks_next;
                rx_bytes_reg      <= rx_bytes_next;
                rx_before_reg     <= rx_before_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_opcode_reg   <= req.opcode;
            s1_rx_count_reg <= req.rx_count;
            s1_action_reg   <= req.action_pending;
            s1_check_reg    <= req.reply_check;
        end
        if (s1_adv)
        begin
            o_done_reg <= r_done;
            o_kind_reg <= r_kind;
            o_tmo_reg  <= r_tmo;
            o_code_reg <= r_code;
            o_send_reg <= r_send;
            o_conn_reg <= connected_next;
            o_busy_reg <= waiting_reply_next;
        end
    end

    assign rsp.valid           = o_valid_reg;
    assign rsp.reply_done      = o_done_reg;
    assign rsp.reply_kind      = o_kind_reg;
    assign rsp.reply_timed_out = o_tmo_reg;
    assign rsp.reply_code      = o_code_reg;
    assign rsp.send_cmd        = o_send_reg;
    assign rsp.link_connected  = o_conn_reg;
    assign rsp.link_is_busy    = o_busy_reg;

    // A reply wait always belongs to an outstanding command
    a_wait_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reply_reg |-> outstanding_reg)
        else $error("waiting for a reply with no command outstanding");

    // A command issued leaves the link busy
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.send_cmd != slps_pkg::SEND_NONE) |-> rsp.link_is_busy)
        else $error("command sent but link not busy");

    // A timeout drops the connection and carries no checker code
    a_tmo_disc: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.reply_timed_out) |-> (!rsp.link_connected && rsp.reply_code == '0))
        else $error("timed out reply left link connected or carried a code");

    // Action commands go out only on a connected link
    a_action_conn: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.send_cmd == slps_pkg::SEND_ACTION) |-> rsp.link_connected)
        else $error("action command sent while disconnected");

endmodule

`default_nettype wire

[rtl/slps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// slps_cfg_regs
// APB register file: busy limit, settle limit, sync interval, sync enable.
// ----------------------------------------------------------------------------
`default_nettype none

module slps_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [slps_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [slps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [slps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output slps_pkg::cfg_t                           cfg
);

    slps_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.busy_limit    <= slps_pkg::BUSY_LIMIT_RST;
            cfg_reg.settle_limit  <= slps_pkg::SETTLE_LIMIT_RST;
            cfg_reg.sync_interval <= slps_pkg::SYNC_INTERVAL_RST;
            cfg_reg.sync_enable   <= slps_pkg::SYNC_ENABLE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                slps_pkg::REG_BUSY_LIMIT:
                    cfg_reg.busy_limit <= pwdata[slps_pkg::LIMIT_W-1:0];
                slps_pkg::REG_SETTLE_LIMIT:
                    cfg_reg.settle_limit <= pwdata[slps_pkg::LIMIT_W-1:0];
                slps_pkg::REG_SYNC_INTERVAL:
                    cfg_reg.sync_interval <= pwdata[slps_pkg::LIMIT_W-1:0];
                slps_pkg::REG_SYNC_ENABLE:
                    cfg_reg.sync_enable <= pwdata[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            slps_pkg::REG_BUSY_LIMIT:
                prdata[slps_pkg::LIMIT_W-1:0] = cfg_reg.busy_limit;
            slps_pkg::REG_SETTLE_LIMIT:
                prdata[slps_pkg::LIMIT_W-1:0] = cfg_reg.settle_limit;
            slps_pkg::REG_SYNC_INTERVAL:
                prdata[slps_pkg::LIMIT_W-1:0] = cfg_reg.sync_interval;
            slps_pkg::REG_SYNC_ENABLE:
                prdata[0] = cfg_reg.sync_enable;
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial link poll supervisor. A directed table
// walks reset behavior, timeouts, reply codes, count clamping and settling,
// then randomized phases run under several register settings, the first two
// at the register extremes. Every result beat is compared with a pinned
// table status or with a cycle-free model of the link state in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int RX_LIMIT       = 128;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 10;
    localparam int PHASE_BEATS    = 110;
    localparam int RECONFIG_ROW   = 3;

    typedef struct packed {
        logic                            opcode;
        logic [slps_pkg::RX_COUNT_W-1:0] rx_count;
        logic                            action_pending;
        logic [slps_pkg::CHECK_W-1:0]    reply_check;
    } link_req_t;

    typedef struct packed {
        logic                         done;
        logic                         kind;
        logic                         timed_out;
        logic [slps_pkg::CHECK_W-1:0] code;
        slps_pkg::send_cmd_t          send;
        logic                         connected;
        logic                         busy;
    } link_status_t;

    typedef struct packed {
        link_req_t    beat;
        logic         pinned;
        link_status_t want;
    } dir_row_t;

    localparam link_status_t ALL_CLEAR = '0;

    // Rows before RECONFIG_ROW run on reset register values; the rest run
    // with busy_limit 2, settle_limit 1, sync_interval 0.
    localparam dir_row_t DIRECTED [25] = '{
        '{'{slps_pkg::OP_IDLE_LINE, 8'd0,   1'b0, 3'd0}, 1'b1, ALL_CLEAR},
        '{'{slps_pkg::OP_IDLE_LINE, 8'd255, 1'b1, 3'd7}, 1'b1, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b1, 3'd7}, 1'b1, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd0}, 1'b1,
          '{1'b0, slps_pkg::KIND_SYNC, 1'b0, 3'd0, slps_pkg::SEND_SYNC, 1'b0, 1'b1}},
        '{'{slps_pkg::OP_TICK,      8'd5,   1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b1, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        // first command after reset resolves as a timeout
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd5}, 1'b1,
          '{1'b1, slps_pkg::KIND_SYNC, 1'b1, 3'd0, slps_pkg::SEND_SYNC, 1'b0, 1'b1}},
        '{'{slps_pkg::OP_IDLE_LINE, 8'd200, 1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b1, 3'd7}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b1, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_IDLE_LINE, 8'd1,   1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_IDLE_LINE, 8'd128, 1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd3}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_IDLE_LINE, 8'd0,   1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_IDLE_LINE, 8'd129, 1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd6}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b0, 3'd2}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_IDLE_LINE, 8'd255, 1'b0, 3'd0}, 1'b0, ALL_CLEAR},
        '{'{slps_pkg::OP_TICK,      8'd0,   1'b1, 3'd1}, 1'b0, ALL_CLEAR}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [slps_pkg::APB_ADDR_W-1:0] paddr;
    logic [slps_pkg::APB_DATA_W-1:0] pwdata;
    logic [slps_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    slps_req_if req_ch ();
    slps_rsp_if rsp_ch ();

    serial_link_poll_supervisor #(
        .RX_BUFFER_BYTES (RX_LIMIT),
        .COUNTER_BITS    (16)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Link model: register copy and link state
    slps_pkg::cfg_t link_cfg;
    logic         awaiting;
    logic [15:0]  busy_cnt;
    logic [15:0]  sync_cnt;
    logic         link_up;
    logic         link_up_prev;
    logic         cmd_open;
    logic         reply_missing;
    logic         open_kind;
    logic         settling;
    logic [15:0]  settle_cnt;
    logic [7:0]   rx_seen;
    logic [7:0]   rx_seen_prev;

    link_status_t status_due [$];
    link_status_t due_status;
    link_status_t last_pred;

    bit           calm_mode = 1'b0;
    int unsigned  fault_count = 0;
    int unsigned  stall_cycles = 0;
    int unsigned  hold_left = 0;
    int unsigned  n_beats = 0;
    int unsigned  n_timeouts = 0;
    int unsigned  n_coded = 0;
    int unsigned  n_syncs = 0;
    int unsigned  n_actions = 0;

    function automatic logic [15:0] count_up(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic slps_pkg::send_cmd_t launch_cmd(input logic kind);
        busy_cnt  = '0;
        awaiting  = 1'b1;
        cmd_open  = 1'b1;
        open_kind = kind;
        return (kind == slps_pkg::KIND_ACTION) ? slps_pkg::SEND_ACTION : slps_pkg::SEND_SYNC;
    endfunction

    function automatic slps_pkg::send_cmd_t sync_due();
        if (sync_cnt >= link_cfg.sync_interval)
        begin
            sync_cnt = '0;
            return launch_cmd(slps_pkg::KIND_SYNC);
        end
        sync_cnt = count_up(sync_cnt);
        return slps_pkg::SEND_NONE;
    endfunction

    function automatic link_status_t predict_link_status(input link_req_t b);
        link_status_t s;
        logic [7:0]   rxc;
        logic         clear_to_send;
        s = '0;
        clear_to_send = 1'b0;
        if (b.opcode == slps_pkg::OP_IDLE_LINE)
        begin
            rxc = (b.rx_count > RX_LIMIT) ? 8'(RX_LIMIT) : b.rx_count;
            rx_seen = rxc;
            if (rxc != 0)
                awaiting = 1'b0;
        end
        else if (awaiting)
        begin
            busy_cnt = count_up(busy_cnt);
            if (busy_cnt > link_cfg.busy_limit)
            begin
                reply_missing = 1'b1;
                awaiting      = 1'b0;
            end
        end
        else
        begin
            if (cmd_open)
            begin
                s.done = 1'b1;
                s.kind = open_kind;
                if (reply_missing)
                begin
                    reply_missing = 1'b0;
                    s.timed_out   = 1'b1;
                end
                else
                    s.code = b.reply_check;
                cmd_open = 1'b0;
                link_up  = ~s.timed_out;
            end
            // a fresh connection waits for the receive count to stop moving
            if (!link_up_prev && link_up)
                settling = 1'b1;
            link_up_prev = link_up;
            if (!settling)
                clear_to_send = 1'b1;
            else
            begin
                if (rx_seen_prev == rx_seen)
                begin
                    settle_cnt = count_up(settle_cnt);
                    if (settle_cnt >= link_cfg.settle_limit)
                    begin
                        settle_cnt    = '0;
                        settling      = 1'b0;
                        clear_to_send = 1'b1;
                    end
                end
                else
                    settle_cnt = '0;
                if (!clear_to_send)
                    rx_seen_prev = rx_seen;
            end
            if (clear_to_send)
            begin
                if (!link_up)
                    s.send = sync_due();
                else if (b.action_pending)
                begin
                    sync_cnt = link_cfg.sync_interval;
                    s.send   = launch_cmd(slps_pkg::KIND_ACTION);
                end
                else if (link_cfg.sync_enable)
                    s.send = sync_due();
            end
        end
        s.connected = link_up;
        s.busy      = awaiting;
        return s;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long stretch
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Idle events mostly while a reply is awaited, as a live link would see
    function automatic link_req_t make_beat();
        link_req_t   b;
        int unsigned r;
        r = $urandom_range(0, 99);
        b.opcode = ((awaiting && r < 30) || (!awaiting && r < 6)) ? slps_pkg::OP_IDLE_LINE
                                                                  : slps_pkg::OP_TICK;
        case ($urandom_range(0, 4))
            0: b.rx_count = 8'($urandom_range(0, 255));
            1: b.rx_count = 8'($urandom_range(RX_LIMIT - 2, RX_LIMIT + 2));
            2: b.rx_count = rx_seen;
            3: b.rx_count = 8'($urandom_range(1, 4));
            default: b.rx_count = '0;
        endcase
        b.action_pending = 1'($urandom_range(0, 1));
        b.reply_check    = 3'($urandom_range(0, 7));
        return b;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    task automatic push_beat(input link_req_t b, input logic pinned,
                             input link_status_t pinned_status);
        int unsigned gap;
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= b.opcode;
        req_ch.rx_count       <= b.rx_count;
        req_ch.action_pending <= b.action_pending;
        req_ch.reply_check    <= b.reply_check;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        last_pred = predict_link_status(b);
        status_due.push_back(pinned ? pinned_status : last_pred);
        n_beats++;
        if (last_pred.done)
        begin
            if (last_pred.timed_out)
                n_timeouts++;
            else
                n_coded++;
        end
        if (last_pred.send == slps_pkg::SEND_SYNC)
            n_syncs++;
        if (last_pred.send == slps_pkg::SEND_ACTION)
            n_actions++;
        @(negedge clk);
        gap = pick_gap();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
        logic [slps_pkg::APB_DATA_W-1:0] word;
        word        = $urandom();
        word[15:0]  = value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (idx)
            slps_pkg::REG_BUSY_LIMIT:    link_cfg.busy_limit    = word[15:0];
            slps_pkg::REG_SETTLE_LIMIT:  link_cfg.settle_limit  = word[15:0];
            slps_pkg::REG_SYNC_INTERVAL: link_cfg.sync_interval = word[15:0];
            slps_pkg::REG_SYNC_ENABLE:   link_cfg.sync_enable   = word[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_write_all(input logic [15:0] busy_v, input logic [15:0] settle_v,
                                 input logic [15:0] interval_v, input logic en_v);
        cfg_write(slps_pkg::REG_BUSY_LIMIT, busy_v);
        cfg_write(slps_pkg::REG_SETTLE_LIMIT, settle_v);
        cfg_write(slps_pkg::REG_SYNC_INTERVAL, interval_v);
        cfg_write(slps_pkg::REG_SYNC_ENABLE, {15'd0, en_v});
    endtask

    // Result sink: random back-pressure
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                hold_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (status_due.size() == 0)
            begin
                $error("result beat arrived with no status waiting");
                fault_count++;
            end
            else
            begin
                due_status = status_due.pop_front();
                check_field("reply_done", due_status.done, rsp_ch.reply_done);
                check_field("reply_kind", due_status.kind, rsp_ch.reply_kind);
                check_field("reply_timed_out", due_status.timed_out, rsp_ch.reply_timed_out);
                check_field("reply_code", due_status.code, rsp_ch.reply_code);
                check_field("send_cmd", due_status.send, rsp_ch.send_cmd);
                check_field("link_connected", due_status.connected, rsp_ch.link_connected);
                check_field("link_is_busy", due_status.busy, rsp_ch.link_is_busy);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles > WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        req_ch.valid          = 1'b0;
        req_ch.opcode         = slps_pkg::OP_TICK;
        req_ch.rx_count       = '0;
        req_ch.action_pending = 1'b0;
        req_ch.reply_check    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        link_cfg.busy_limit    = slps_pkg::BUSY_LIMIT_RST;
        link_cfg.settle_limit  = slps_pkg::SETTLE_LIMIT_RST;
        link_cfg.sync_interval = slps_pkg::SYNC_INTERVAL_RST;
        link_cfg.sync_enable   = slps_pkg::SYNC_ENABLE_RST;
        awaiting      = 1'b0;
        busy_cnt      = '0;
        sync_cnt      = '0;
        link_up       = 1'b0;
        link_up_prev  = 1'b0;
        cmd_open      = 1'b0;
        reply_missing = 1'b1;
        open_kind     = slps_pkg::KIND_SYNC;
        settling      = 1'b0;
        settle_cnt    = '0;
        rx_seen       = '0;
        rx_seen_prev  = '0;
        last_pred     = ALL_CLEAR;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (i == RECONFIG_ROW)
            begin
                drain_results();
                cfg_write_all(16'd2, 16'd1, 16'd0, 1'b1);
            end
            push_beat(DIRECTED[i].beat, DIRECTED[i].pinned, DIRECTED[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0: cfg_write_all(16'd0, 16'd0, 16'd0, 1'b0);
                1: cfg_write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                default: cfg_write_all(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
                                       16'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
            endcase
            calm_mode = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                // hold the sender until the pipeline empties now and then
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                push_beat(make_beat(), 1'b0, ALL_CLEAR);
            end
        end

        drain_results();
        repeat (6) @(negedge clk);

        $display("Ran %0d beats: directed table and %0d register settings",
                 n_beats, PHASES + 2);
        $display("Replies: %0d timed out, %0d with checker code; sent %0d sync, %0d action",
                 n_timeouts, n_coded, n_syncs, n_actions);
        if (fault_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/slps_pkg.sv
rtl/slps_ifs.sv
rtl/slps_cfg_regs.sv
rtl/serial_link_poll_supervisor.sv
tb/tb_top.sv
